### src/stscan_pkg.sv
// shared types and constants of the script token scanner
package stscan_pkg;

    localparam int POS_BITS    = 16;
    localparam int START_BITS  = 16;
    localparam int LEN_BITS    = 16;
    localparam int KIND_BITS   = 5;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [START_BITS-1:0] start;
        logic [LEN_BITS-1:0]   length;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

### src/stscan_engine.sv
// scanner state and per-byte token logic
module stscan_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           text_byte,
    output stscan_pkg::push_t    push
);
    import stscan_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_OPER, M_MATH, M_SLASH,
        M_LINE, M_BLOCK, M_STR_DQ, M_STR_SQ, M_HALT
    } mode_t;

    localparam logic [KIND_BITS-1:0] K_IDENT   = KIND_BITS'(0);
    localparam logic [KIND_BITS-1:0] K_KW0     = KIND_BITS'(1);
    localparam logic [KIND_BITS-1:0] K_INT     = KIND_BITS'(4);
    localparam logic [KIND_BITS-1:0] K_FLOAT   = KIND_BITS'(5);
    localparam logic [KIND_BITS-1:0] K_COMP    = KIND_BITS'(6);
    localparam logic [KIND_BITS-1:0] K_LOGIC   = KIND_BITS'(7);
    localparam logic [KIND_BITS-1:0] K_MATH    = KIND_BITS'(8);
    localparam logic [KIND_BITS-1:0] K_STRING  = KIND_BITS'(9);
    localparam logic [KIND_BITS-1:0] K_SEP0    = KIND_BITS'(10);
    localparam logic [KIND_BITS-1:0] K_END     = KIND_BITS'(20);
    localparam logic [KIND_BITS-1:0] K_STOP    = KIND_BITS'(21);
    localparam logic [KIND_BITS-1:0] K_ERR_STR = KIND_BITS'(22);
    localparam logic [KIND_BITS-1:0] K_ERR_COM = KIND_BITS'(23);

    // operator head kind, reused as the star bit inside a block comment
    localparam logic [1:0] OFK_LOGIC   = 2'd0;
    localparam logic [1:0] OFK_COMP    = 2'd1;
    localparam logic [1:0] OFK_BANG    = 2'd2;
    localparam logic [1:0] OFK_NO_STAR = 2'd0;
    localparam logic [1:0] OFK_STAR    = 2'd1;

    localparam logic [63:0] KW_FUNCTION = "function";
    localparam logic [63:0] KW_PRINT    = {"print", 24'h0};
    localparam logic [63:0] KW_RETURN   = {"return", 16'h0};
    localparam logic [LEN_BITS-1:0] KW_LEN0 = LEN_BITS'(8);
    localparam logic [LEN_BITS-1:0] KW_LEN1 = LEN_BITS'(5);
    localparam logic [LEN_BITS-1:0] KW_LEN2 = LEN_BITS'(6);
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'd32 || b == 8'd9 || b == 8'd10 || b == 8'd11 || b == 8'd13 || b == 8'd15;
    endfunction

    function automatic logic is_lbreak(input logic [7:0] b);
        return b == 8'd10 || b == 8'd11 || b == 8'd13 || b == 8'd15;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return (b >= "0" && b <= "9") || b == ".";
    endfunction

    function automatic logic is_lop(input logic [7:0] b);
        return b == ">" || b == "<" || b == "=" || b == "&" || b == "|" || b == "!";
    endfunction

    function automatic logic is_mop(input logic [7:0] b);
        return b == "+" || b == "-" || b == "*" || b == "/" || b == "^" || b == "%";
    endfunction

    function automatic logic [7:0] kw_char(input logic [63:0] kw, input logic [2:0] i);
        return kw[63 - 8 * int'(i) -: 8];
    endfunction

    function automatic logic [2:0] kw_filter(input logic [2:0] cand,
                                             input logic [LEN_BITS-1:0] idx,
                                             input logic [7:0] b);
        logic [2:0] r;
        r    = cand;
        r[0] = cand[0] && idx < KW_LEN0 && kw_char(KW_FUNCTION, idx[2:0]) == b;
        r[1] = cand[1] && idx < KW_LEN1 && kw_char(KW_PRINT, idx[2:0]) == b;
        r[2] = cand[2] && idx < KW_LEN2 && kw_char(KW_RETURN, idx[2:0]) == b;
        return r;
    endfunction

    mode_t               mode_reg, mode_next;
    pos_t                pos_reg, pos_next;
    pos_t                tstart_reg, tstart_next;
    logic [1:0]          pcount_reg, pcount_next;
    logic [2:0]          kwc_reg, kwc_next;
    logic [1:0]          ofk_reg, ofk_next;
    logic [LEN_BITS-1:0] tlen_reg, tlen_next;

    // start of a new token
    mode_t               st_mode;
    pos_t                st_tstart;
    logic [1:0]          st_pcount;
    logic [2:0]          st_kwc;
    logic [1:0]          st_ofk;
    logic [LEN_BITS-1:0] st_tlen;
    logic                st_emit;
    logic [KIND_BITS-1:0] st_kind;
    logic [LEN_BITS-1:0] st_rlen;
    logic                st_restart;

    logic [LEN_BITS-1:0] grown;
    logic                use_start;
    logic                m_emit;
    result_t             m_res;
    result_t             s_res;
    logic                restart;
    logic [KIND_BITS-1:0] ident_kind;

    assign grown = (tlen_reg == LEN_MAX) ? tlen_reg : tlen_reg + LEN_BITS'(1);

    always_comb
    begin
        priority if (kwc_reg[0] && tlen_reg == KW_LEN0)
            ident_kind = K_KW0;
        else if (kwc_reg[1] && tlen_reg == KW_LEN1)
            ident_kind = K_KW0 + KIND_BITS'(1);
        else if (kwc_reg[2] && tlen_reg == KW_LEN2)
            ident_kind = K_KW0 + KIND_BITS'(2);
        else
            ident_kind = K_IDENT;
    end

    always_comb
    begin
        st_mode    = M_IDLE;
        st_tstart  = tstart_reg;
        st_pcount  = pcount_reg;
        st_kwc     = kwc_reg;
        st_ofk     = ofk_reg;
        st_tlen    = tlen_reg;
        st_emit    = 1'b0;
        st_kind    = K_END;
        st_rlen    = '0;
        st_restart = 1'b0;
        priority if (text_byte == 8'd0)
        begin
            st_emit    = 1'b1;
            st_restart = 1'b1;
        end
        else if (is_ws(text_byte))
        begin
            st_mode = M_IDLE;
        end
        else if (is_alpha(text_byte) || text_byte == "_" || is_num(text_byte)
                 || is_lop(text_byte) || is_mop(text_byte)
                 || text_byte == "\"" || text_byte == "'")
        begin
            st_tstart = pos_reg;
            st_tlen   = LEN_BITS'(1);
            priority if (is_alpha(text_byte) || text_byte == "_")
            begin
                st_mode = M_IDENT;
                st_kwc  = kw_filter(3'b111, '0, text_byte);
            end
            else if (is_num(text_byte))
            begin
                st_mode   = M_NUMBER;
                st_pcount = (text_byte == ".") ? 2'd1 : 2'd0;
            end
            else if (is_lop(text_byte))
            begin
                st_mode = M_OPER;
                st_ofk  = (text_byte == "!") ? OFK_BANG
                        : ((text_byte == "&" || text_byte == "|") ? OFK_LOGIC : OFK_COMP);
            end
            else if (text_byte == "/")
                st_mode = M_SLASH;
            else if (is_mop(text_byte))
                st_mode = M_MATH;
            else
                st_mode = (text_byte == "\"") ? M_STR_DQ : M_STR_SQ;
        end
        else
        begin
            st_emit = 1'b1;
            st_rlen = LEN_BITS'(1);
            unique case (text_byte)
                "{":     st_kind = K_SEP0;
                "}":     st_kind = K_SEP0 + KIND_BITS'(1);
                "(":     st_kind = K_SEP0 + KIND_BITS'(2);
                ")":     st_kind = K_SEP0 + KIND_BITS'(3);
                "[":     st_kind = K_SEP0 + KIND_BITS'(4);
                "]":     st_kind = K_SEP0 + KIND_BITS'(5);
                ":":     st_kind = K_SEP0 + KIND_BITS'(6);
                ";":     st_kind = K_SEP0 + KIND_BITS'(7);
                ",":     st_kind = K_SEP0 + KIND_BITS'(8);
                "#":     st_kind = K_SEP0 + KIND_BITS'(9);
                default:
                begin
                    st_kind = K_STOP;
                    st_mode = M_HALT;
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        pcount_next = pcount_reg;
        kwc_next    = kwc_reg;
        ofk_next    = ofk_reg;
        tlen_next   = tlen_reg;
        use_start   = 1'b0;
        restart     = 1'b0;
        m_emit      = 1'b0;
        m_res.kind   = K_MATH;
        m_res.start  = START_BITS'(tstart_reg);
        m_res.length = tlen_reg;
        m_res.last   = 1'b0;
        unique case (mode_reg)
            M_IDENT:
            begin
                if (is_alpha(text_byte) || is_num(text_byte) || text_byte == "_")
                begin
                    kwc_next  = kw_filter(kwc_reg, tlen_reg, text_byte);
                    tlen_next = grown;
                end
                else
                begin
                    m_emit     = 1'b1;
                    m_res.kind = ident_kind;
                    use_start  = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (is_num(text_byte))
                begin
                    if (text_byte == "." && pcount_reg < 2'd2)
                        pcount_next = pcount_reg + 2'd1;
                    tlen_next = grown;
                end
                else
                begin
                    m_emit     = 1'b1;
                    m_res.kind = (pcount_reg == 2'd0) ? K_INT
                               : ((pcount_reg == 2'd1) ? K_FLOAT : K_IDENT);
                    use_start  = 1'b1;
                end
            end
            M_OPER:
            begin
                if (is_lop(text_byte))
                begin
                    if (ofk_reg == OFK_BANG)
                        ofk_next = (text_byte == "=") ? OFK_COMP : OFK_LOGIC;
                    tlen_next = grown;
                end
                else
                begin
                    m_emit     = 1'b1;
                    m_res.kind = (ofk_reg == OFK_COMP) ? K_COMP : K_LOGIC;
                    use_start  = 1'b1;
                end
            end
            M_MATH:
            begin
                if (is_mop(text_byte))
                    tlen_next = grown;
                else
                begin
                    m_emit    = 1'b1;
                    use_start = 1'b1;
                end
            end
            M_SLASH:
            begin
                priority if (text_byte == "/")
                    mode_next = M_LINE;
                else if (text_byte == "*")
                begin
                    mode_next = M_BLOCK;
                    ofk_next  = OFK_STAR;
                    tlen_next = grown;
                end
                else if (is_mop(text_byte))
                begin
                    mode_next = M_MATH;
                    tlen_next = grown;
                end
                else
                begin
                    m_emit    = 1'b1;
                    use_start = 1'b1;
                end
            end
            M_LINE:
            begin
                if (text_byte == 8'd0)
                begin
                    m_emit       = 1'b1;
                    m_res.kind   = K_END;
                    m_res.start  = START_BITS'(pos_reg);
                    m_res.length = '0;
                    restart      = 1'b1;
                end
                else if (is_lbreak(text_byte))
                    mode_next = M_IDLE;
            end
            M_BLOCK:
            begin
                priority if (ofk_reg == OFK_STAR && text_byte == "/")
                begin
                    mode_next = M_IDLE;
                    ofk_next  = OFK_NO_STAR;
                end
                else if (text_byte == 8'd0)
                begin
                    m_emit     = 1'b1;
                    m_res.kind = K_ERR_COM;
                    restart    = 1'b1;
                end
                else
                begin
                    ofk_next  = (text_byte == "*") ? OFK_STAR : OFK_NO_STAR;
                    tlen_next = grown;
                end
            end
            M_STR_DQ, M_STR_SQ:
            begin
                if (text_byte == 8'd0)
                begin
                    m_emit     = 1'b1;
                    m_res.kind = K_ERR_STR;
                    restart    = 1'b1;
                end
                else
                begin
                    tlen_next = grown;
                    if (text_byte == ((mode_reg == M_STR_DQ) ? 8'h22 : 8'h27))
                    begin
                        m_emit       = 1'b1;
                        m_res.kind   = K_STRING;
                        m_res.length = grown;
                        mode_next    = M_IDLE;
                    end
                end
            end
            M_HALT:
            begin
                if (text_byte == 8'd0)
                    restart = 1'b1;
            end
            default:
                use_start = 1'b1;
        endcase

        if (use_start)
        begin
            mode_next   = st_mode;
            tstart_next = st_tstart;
            pcount_next = st_pcount;
            kwc_next    = st_kwc;
            ofk_next    = st_ofk;
            tlen_next   = st_tlen;
            restart     = st_restart;
        end

        pos_next = pos_reg + POS_BITS'(1);
        if (restart)
        begin
            mode_next   = M_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            pcount_next = 2'd0;
            kwc_next    = 3'b111;
            ofk_next    = OFK_LOGIC;
            tlen_next   = '0;
        end
    end

    always_comb
    begin
        logic s_emit;
        s_emit       = use_start && st_emit;
        s_res.kind   = st_kind;
        s_res.start  = START_BITS'(pos_reg);
        s_res.length = st_rlen;
        s_res.last   = 1'b1;
        push.count   = 2'(m_emit) + 2'(s_emit);
        push.second  = s_res;
        if (m_emit)
        begin
            push.first      = m_res;
            push.first.last = !s_emit;
        end
        else
            push.first = s_res;
        if (!step)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            pcount_reg <= 2'd0;
            kwc_reg    <= 3'b111;
            ofk_reg    <= OFK_LOGIC;
            tlen_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            pcount_reg <= pcount_next;
            kwc_reg    <= kwc_next;
            ofk_reg    <= ofk_next;
            tlen_reg   <= tlen_next;
        end
    end

    // two results only when a pending token closes on a byte that emits too
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.last && push.second.last && m_emit);

    // a restart always leaves the scanner idle at offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        step && restart |=> mode_reg == M_IDLE && pos_reg == '0 && tlen_reg == '0);

endmodule

### src/stscan_result_queue.sv
// small result queue taking up to two results per cycle
module stscan_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stscan_pkg::push_t    push,
    input  logic                 pop,
    output logic                 room,
    output logic                 head_valid,
    output stscan_pkg::result_t  head
);
    import stscan_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    result_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  do_pop;

    assign head_valid = cnt_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign room       = cnt_reg <= CNT_BITS'(QUEUE_DEPTH - 2);
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(do_pop);
        cnt_next    = cnt_reg + CNT_BITS'(push.count) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_reg + PTR_BITS'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(QUEUE_DEPTH));

    // pointers and fill count stay consistent
    assert property (@(posedge clk) disable iff (!rst_n)
        PTR_BITS'(wr_ptr_reg - rd_ptr_reg) == PTR_BITS'(cnt_reg));

endmodule

### src/script_token_scanner.sv
// top level of the script token scanner
// path: an accepted byte waits in the input register; its results go to the result queue
// throughput: one byte per cycle, paced by the four-entry result queue and one
//   result leaving per cycle; a byte is held while the queue has fewer than two free slots
// reset: scanner idle at text offset 0, input register and result queue empty
module script_token_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);
    import stscan_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       step;
    push_t      push;
    result_t    head;

    assign step     = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= text_byte;
    end

    stscan_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (in_byte_reg),
        .push      (push)
    );

    stscan_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (!out_stall),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

endmodule

### dv/script_token_scanner_tb.sv
// self-checking testbench of the script token scanner: directed table and random token streams
module script_token_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stscan_pkg::*;

    typedef logic [7:0] byte_t;

    typedef enum logic [4:0] {
        KIND_IDENT, KIND_KW_FUNCTION, KIND_KW_PRINT, KIND_KW_RETURN,
        KIND_INT, KIND_FLOAT, KIND_COMP, KIND_LOGIC, KIND_MATH, KIND_STRING,
        KIND_LBRACE, KIND_RBRACE, KIND_LPAREN, KIND_RPAREN, KIND_LBRACKET,
        KIND_RBRACKET, KIND_COLON, KIND_SEMI, KIND_COMMA, KIND_HASH,
        KIND_END, KIND_STOP, KIND_ERR_STRING, KIND_ERR_COMMENT
    } kind_e;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_OPER, MODE_MATH, MODE_SLASH,
        MODE_LINE, MODE_BLOCK, MODE_DQ, MODE_SQ, MODE_HALT
    } mode_e;

    typedef enum logic [1:0] {OPK_LOGIC, OPK_COMP, OPK_BANG} op_head_e;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_e;

    typedef struct {
        byte_t   text;
        bit      typed;
        result_t want;
    } dir_row_t;

    localparam int    RANDOM_ITEMS = 1860;
    localparam int    CYCLE_LIMIT  = 200_000;
    localparam int    DRAIN_CYCLES = 8;
    localparam string LETTERS      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string ID_HEAD      = "abcdefgxyzFPRQ_";
    localparam string ID_BODY      = "abcnrtuxyzPR_.0123456789";
    localparam string DIGITS       = "0123456789";
    localparam string LOP_CHARS    = "><=&|!";
    localparam string MOP_CHARS    = "+-*/^%";
    localparam string SEP_CHARS    = "{}()[]:;,#";
    localparam string WS_CHARS     = " \011\012\013\015\017";
    localparam string BREAKS       = "\012\013\015\017";
    localparam string COMMENT_BODY = "*/a *\012/";
    localparam string UNKNOWN      = "@$`~?\\\001\002\177";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    script_token_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    // scanner state as predicted
    mode_e       sc_mode;
    pos_t        sc_pos;
    pos_t        sc_tok_start;
    logic [1:0]  sc_periods;
    logic [2:0]  sc_kw;
    op_head_e    sc_opk;
    logic        sc_star;
    logic [15:0] sc_len;

    string   kw_word [3] = '{"function", "print", "return"};
    result_t byte_results [$];
    result_t token_queue [$];
    byte_t   text_buf [$];

    int           fail_count = 0;
    int           cycle_count = 0;
    int           sent_bytes = 0;
    int           burst_left = 0;
    bit           steady = 1'b0;
    int           stall_tick = 0;
    stall_style_e stall_style = STALL_NONE;

    dir_row_t dir_rows [24] = '{
        '{8'h00, 1'b1, '{KIND_END, 16'd0, 16'd0, 1'b1}},
        '{8'hFF, 1'b1, '{KIND_STOP, 16'd0, 16'd1, 1'b1}},
        '{"a", 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{"#", 1'b1, '{KIND_HASH, 16'd0, 16'd1, 1'b1}},
        '{"/", 1'b0, '0},
        '{"*", 1'b0, '0},
        '{"/", 1'b0, '0},
        '{"p", 1'b0, '0},
        '{"r", 1'b0, '0},
        '{"i", 1'b0, '0},
        '{"n", 1'b0, '0},
        '{"t", 1'b0, '0},
        '{"!", 1'b0, '0},
        '{"=", 1'b0, '0},
        '{"1", 1'b0, '0},
        '{".", 1'b0, '0},
        '{"2", 1'b0, '0},
        '{"\"", 1'b0, '0},
        '{"s", 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_ERR_STRING, 16'd14, 16'd2, 1'b1}},
        '{"/", 1'b0, '0},
        '{"/", 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_END, 16'd2, 16'd0, 1'b1}}
    };

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit is_lbreak(byte_t b);
        return b == 8'd10 || b == 8'd11 || b == 8'd13 || b == 8'd15;
    endfunction

    function automatic bit is_ws(byte_t b);
        return b == 8'd32 || b == 8'd9 || is_lbreak(b);
    endfunction

    function automatic bit is_alpha(byte_t b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_num(byte_t b);
        return (b >= "0" && b <= "9") || b == ".";
    endfunction

    function automatic bit is_aln(byte_t b);
        return is_alpha(b) || is_num(b) || b == "_";
    endfunction

    function automatic bit is_lop(byte_t b);
        return b == ">" || b == "<" || b == "=" || b == "&" || b == "|" || b == "!";
    endfunction

    function automatic bit is_mop(byte_t b);
        return b == "+" || b == "-" || b == "*" || b == "/" || b == "^" || b == "%";
    endfunction

    function automatic int sep_slot(byte_t b);
        case (b)
            "{": return 0;
            "}": return 1;
            "(": return 2;
            ")": return 3;
            "[": return 4;
            "]": return 5;
            ":": return 6;
            ";": return 7;
            ",": return 8;
            "#": return 9;
            default: return -1;
        endcase
    endfunction

    function automatic byte_t pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void note_token(kind_e k, pos_t s, logic [15:0] len);
        result_t r;
        r.kind = k;
        r.start = s;
        r.length = len;
        r.last = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void restart_text();
        sc_mode = MODE_IDLE;
        sc_pos = '0;
        sc_tok_start = '0;
        sc_periods = 2'd0;
        sc_kw = 3'b111;
        sc_opk = OPK_LOGIC;
        sc_star = 1'b0;
        sc_len = '0;
    endfunction

    function automatic void lengthen();
        if (sc_len != 16'hFFFF)
            sc_len = sc_len + 16'd1;
    endfunction

    function automatic void open_token(mode_e m, pos_t p);
        sc_mode = m;
        sc_tok_start = p;
        sc_len = 16'd1;
    endfunction

    function automatic void kw_narrow(byte_t b);
        int k;
        for (k = 0; k < 3; k++)
            if (sc_len >= kw_word[k].len() || kw_word[k][sc_len] != b)
                sc_kw[k] = 1'b0;
    endfunction

    function automatic kind_e ident_kind();
        int k;
        for (k = 0; k < 3; k++)
            if (sc_kw[k] && sc_len == kw_word[k].len())
                return kind_e'(KIND_KW_FUNCTION + k);
        return KIND_IDENT;
    endfunction

    // a byte seen with no token open; returns 1 when the text restarts
    function automatic bit scan_fresh(byte_t b, pos_t p);
        int s;
        s = sep_slot(b);
        sc_mode = MODE_IDLE;
        if (b == 8'h00)
        begin
            note_token(KIND_END, p, 16'd0);
            restart_text();
            return 1'b1;
        end
        if (is_ws(b))
            return 1'b0;
        if (is_alpha(b) || b == "_")
        begin
            open_token(MODE_IDENT, p);
            sc_kw = 3'b111;
            sc_len = '0;
            kw_narrow(b);
            sc_len = 16'd1;
        end
        else if (is_num(b))
        begin
            open_token(MODE_NUMBER, p);
            sc_periods = (b == ".") ? 2'd1 : 2'd0;
        end
        else if (is_lop(b))
        begin
            open_token(MODE_OPER, p);
            sc_opk = (b == "!") ? OPK_BANG : ((b == "&" || b == "|") ? OPK_LOGIC : OPK_COMP);
        end
        else if (b == "/")
            open_token(MODE_SLASH, p);
        else if (is_mop(b))
            open_token(MODE_MATH, p);
        else if (b == "\"")
            open_token(MODE_DQ, p);
        else if (b == "'")
            open_token(MODE_SQ, p);
        else if (s >= 0)
            note_token(kind_e'(KIND_LBRACE + s), p, 16'd1);
        else
        begin
            note_token(KIND_STOP, p, 16'd1);
            sc_mode = MODE_HALT;
        end
        return 1'b0;
    endfunction

    function automatic void predict_tokens(byte_t b);
        pos_t    p;
        bit      restarted;
        result_t r;
        p = sc_pos;
        restarted = 1'b0;
        byte_results.delete();
        case (sc_mode)
            MODE_IDENT:
            begin
                if (is_aln(b))
                begin
                    kw_narrow(b);
                    lengthen();
                end
                else
                begin
                    note_token(ident_kind(), sc_tok_start, sc_len);
                    restarted = scan_fresh(b, p);
                end
            end
            MODE_NUMBER:
            begin
                if (is_num(b))
                begin
                    if (b == "." && sc_periods < 2'd2)
                        sc_periods = sc_periods + 2'd1;
                    lengthen();
                end
                else
                begin
                    note_token(sc_periods == 2'd0 ? KIND_INT :
                               (sc_periods == 2'd1 ? KIND_FLOAT : KIND_IDENT),
                               sc_tok_start, sc_len);
                    restarted = scan_fresh(b, p);
                end
            end
            MODE_OPER:
            begin
                if (is_lop(b))
                begin
                    if (sc_opk == OPK_BANG)
                        sc_opk = (b == "=") ? OPK_COMP : OPK_LOGIC;
                    lengthen();
                end
                else
                begin
                    note_token(sc_opk == OPK_COMP ? KIND_COMP : KIND_LOGIC, sc_tok_start, sc_len);
                    restarted = scan_fresh(b, p);
                end
            end
            MODE_MATH:
            begin
                if (is_mop(b))
                    lengthen();
                else
                begin
                    note_token(KIND_MATH, sc_tok_start, sc_len);
                    restarted = scan_fresh(b, p);
                end
            end
            MODE_SLASH:
            begin
                if (b == "/")
                    sc_mode = MODE_LINE;
                else if (b == "*")
                begin
                    // the opening star already counts toward a close
                    sc_mode = MODE_BLOCK;
                    sc_star = 1'b1;
                    lengthen();
                end
                else if (is_mop(b))
                begin
                    sc_mode = MODE_MATH;
                    lengthen();
                end
                else
                begin
                    note_token(KIND_MATH, sc_tok_start, sc_len);
                    restarted = scan_fresh(b, p);
                end
            end
            MODE_LINE:
            begin
                if (b == 8'h00)
                begin
                    note_token(KIND_END, p, 16'd0);
                    restart_text();
                    restarted = 1'b1;
                end
                else if (is_lbreak(b))
                    sc_mode = MODE_IDLE;
            end
            MODE_BLOCK:
            begin
                if (sc_star && b == "/")
                begin
                    sc_mode = MODE_IDLE;
                    sc_star = 1'b0;
                end
                else if (b == 8'h00)
                begin
                    note_token(KIND_ERR_COMMENT, sc_tok_start, sc_len);
                    restart_text();
                    restarted = 1'b1;
                end
                else
                begin
                    sc_star = (b == "*");
                    lengthen();
                end
            end
            MODE_DQ, MODE_SQ:
            begin
                if (b == 8'h00)
                begin
                    note_token(KIND_ERR_STRING, sc_tok_start, sc_len);
                    restart_text();
                    restarted = 1'b1;
                end
                else
                begin
                    lengthen();
                    if (b == (sc_mode == MODE_DQ ? 8'h22 : 8'h27))
                    begin
                        note_token(KIND_STRING, sc_tok_start, sc_len);
                        sc_mode = MODE_IDLE;
                    end
                end
            end
            MODE_HALT:
            begin
                if (b == 8'h00)
                begin
                    restart_text();
                    restarted = 1'b1;
                end
            end
            default:
                restarted = scan_fresh(b, p);
        endcase
        if (!restarted)
            sc_pos = p + 1'b1;
        if (byte_results.size() > 0)
        begin
            r = byte_results.pop_back();
            r.last = 1'b1;
            byte_results.push_back(r);
        end
    endfunction

    // one program text made of random pieces, mostly well formed
    function automatic void compose_text();
        int    pieces;
        int    len;
        int    k;
        int    i;
        byte_t q;
        byte_t c;
        text_buf.delete();
        pieces = $urandom_range(1, 12);
        repeat (pieces)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    len = $urandom_range(1, 10);
                    text_buf.push_back(pick(ID_HEAD));
                    repeat (len - 1) text_buf.push_back(pick(ID_BODY));
                end
                3, 4:
                begin
                    k = $urandom_range(0, 2);
                    len = kw_word[k].len();
                    if ($urandom_range(0, 3) == 0)
                        len = $urandom_range(1, len);
                    for (i = 0; i < len; i++)
                        text_buf.push_back(kw_word[k][i]);
                    if ($urandom_range(0, 3) == 0)
                        text_buf.push_back(pick(ID_BODY));
                end
                5, 6:
                begin
                    len = $urandom_range(1, 6);
                    repeat (len)
                        text_buf.push_back($urandom_range(0, 4) == 0 ? 8'h2E : pick(DIGITS));
                end
                7:
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_buf.push_back(pick(LOP_CHARS));
                end
                8:
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_buf.push_back(pick(MOP_CHARS));
                end
                9:
                begin
                    q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
                    text_buf.push_back(q);
                    len = $urandom_range(0, 6);
                    repeat (len)
                    begin
                        c = ($urandom_range(0, 4) == 0) ? byte_t'($urandom_range(1, 255))
                                                        : byte_t'($urandom_range(32, 126));
                        text_buf.push_back(c == q ? 8'h78 : c);
                    end
                    if ($urandom_range(0, 9) != 0)
                        text_buf.push_back(q);
                end
                10:
                begin
                    text_buf.push_back("/");
                    text_buf.push_back("/");
                    len = $urandom_range(0, 8);
                    repeat (len) text_buf.push_back(byte_t'($urandom_range(1, 255)));
                    text_buf.push_back(pick(BREAKS));
                end
                11:
                begin
                    text_buf.push_back("/");
                    text_buf.push_back("*");
                    if ($urandom_range(0, 4) == 0)
                        text_buf.push_back("/");
                    else
                    begin
                        len = $urandom_range(0, 8);
                        repeat (len)
                            text_buf.push_back($urandom_range(0, 3) == 0
                                               ? byte_t'($urandom_range(1, 255))
                                               : pick(COMMENT_BODY));
                        if ($urandom_range(0, 9) != 0)
                        begin
                            text_buf.push_back("*");
                            text_buf.push_back("/");
                        end
                    end
                end
                12, 13, 14:
                    text_buf.push_back(pick(SEP_CHARS));
                15, 16:
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_buf.push_back(pick(WS_CHARS));
                end
                17:
                begin
                    if ($urandom_range(0, 2) == 0)
                        text_buf.push_back($urandom_range(0, 1)
                                           ? byte_t'($urandom_range(128, 255))
                                           : pick(UNKNOWN));
                    else
                        text_buf.push_back(pick(SEP_CHARS));
                end
                18:
                begin
                    if ($urandom_range(0, 2) == 0)
                        text_buf.push_back(byte_t'($urandom_range(0, 255)));
                end
                default:
                begin
                    text_buf.push_back(pick(DIGITS));
                    text_buf.push_back(pick(LETTERS));
                end
            endcase
            if ($urandom_range(0, 1))
                text_buf.push_back(pick(WS_CHARS));
        end
        if ($urandom_range(0, 19) != 0)
            text_buf.push_back(8'h00);
    endfunction

    task automatic send_byte(input byte_t b, input bit typed = 1'b0, input result_t want = '0);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        sent_bytes++;
        predict_tokens(b);
        if (typed)
            token_queue.push_back(want);
        else
            foreach (byte_results[i])
                token_queue.push_back(byte_results[i]);
    endtask

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 300 == 0)
            stall_style <= stall_style_e'($urandom_range(0, 3));
        case (stall_style)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: out_stall <= (stall_tick % 7 < 3);
            default:        out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_queue.size() == 0)
            begin
                $error("unexpected result transaction: kind %0d start %0d length %0d",
                       token_kind, token_start, token_length);
                fail_count++;
            end
            else
            begin
                want = token_queue.pop_front();
                if (token_kind !== want.kind)
                begin
                    $error("token_kind mismatch: expected %0d, actual %0d", want.kind, token_kind);
                    fail_count++;
                end
                if (token_start !== want.start)
                begin
                    $error("token_start mismatch: expected %0d, actual %0d",
                           want.start, token_start);
                    fail_count++;
                end
                if (token_length !== want.length)
                begin
                    $error("token_length mismatch: expected %0d, actual %0d",
                           want.length, token_length);
                    fail_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run mismatch: expected %0d, actual %0d",
                           want.last, last_of_run);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int base_count;
        restart_text();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].text, dir_rows[i].typed, dir_rows[i].want);

        base_count = sent_bytes;
        while (sent_bytes - base_count < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 9) == 0);
            compose_text();
            foreach (text_buf[i])
                send_byte(text_buf[i]);
        end
        in_valid <= 1'b0;

        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && token_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
src/stscan_pkg.sv
src/stscan_engine.sv
src/stscan_result_queue.sv
src/script_token_scanner.sv
dv/script_token_scanner_tb.sv
